@@ sv/bao_pkg.sv @@
// ----------------------------------------------------------------------------
// Brightness average package
// Shared constants, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bao_pkg;

    localparam int NUM_CH          = 5;
    localparam int DATA_W          = 8;
    localparam int FRAC_W          = 8;
    localparam int MEAN_W          = 16;
    localparam int REJ_W           = 6;
    localparam int QSTEP_W         = 4;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int IN_DATA_W       = NUM_CH * DATA_W;
    localparam int OUT_DATA_W      = 96;

    localparam logic [DATA_W-1:0] THRESHOLD_RESET = 8'd10;

    // channel slots in the sum array
    localparam logic [2:0] CH_ONE   = 3'd0;
    localparam logic [2:0] CH_TWO   = 3'd1;
    localparam logic [2:0] CH_THREE = 3'd2;
    localparam logic [2:0] CH_FOUR  = 3'd3;
    localparam logic [2:0] CH_MARK  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_RES_START,
        S_RES_WAIT,
        S_OUT
    } bao_state_t;

    typedef struct packed {
        logic [REJ_W-1:0]               rej_four;
        logic [REJ_W-1:0]               rej_three;
        logic [NUM_CH-1:0][MEAN_W-1:0]  mean;
    } bao_result_t;

endpackage

`default_nettype wire

@@ sv/brightness_average_outlier_reject_top.sv @@
// ----------------------------------------------------------------------------
// Brightness average with outlier rejection
// Averages five brightness channels over a run of samples; channels three and
// four drop their first sample that strays from the running mean.
// ----------------------------------------------------------------------------
// s_axis carries one sample per word, tlast marking the last of a run; m_axis
// carries one result word per run. cfg sets the outlier threshold; it is
// always ready and should only be written while the block is idle.
// All division goes through one 16-step serial divider. A sample updating
// both running means holds s_axis_tready low until both quotients are done,
// so no new word is accepted before the last is through; one updating a
// single mean holds it for one quotient, and one updating neither, or one
// beyond a full run, holds it without any quotient. A last sample adds five
// quotients before the result word is offered.
// rst_n clears the run state and sets the threshold to 10; no clearing pass.
// The result sits in an output register and the next run is accepted while it
// waits; a further result waits in the core until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module brightness_average_outlier_reject_top
    import bao_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // road_left_outer, road_left_inner, road_right_inner, road_right_outer,
    // marking_level
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // mean_one, mean_two, mean_three, mean_four, mean_marking,
    // rejected_three_at, rejected_four_at, 4 zero bits
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [DATA_W-1:0]     cfg_data
);

    localparam int PAD_W = OUT_DATA_W - NUM_CH * MEAN_W - 2 * REJ_W;

    logic [DATA_W-1:0]     thr_reg,      thr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  res_valid;
    logic                  res_ready;
    bao_result_t           res;

    bao_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{PAD_W{1'b0}}, res};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ sv/bao_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider for floor(sum * 256 / divisor), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bao_div
    import bao_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [DATA_W+$clog2(MAX_SAMPLES)-1:0] sum,
    input  wire logic [$clog2(MAX_SAMPLES+1)-1:0]    divisor,
    output logic                                     done,
    output logic [MEAN_W-1:0]                        quot
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [QSTEP_W-1:0] LAST_STEP = QSTEP_W'(MEAN_W - 1);

    logic [CNT_W-1:0]   rem_reg,  rem_next;
    logic [CNT_W-1:0]   dvs_reg,  dvs_next;
    logic [MEAN_W-1:0]  sh_reg,   sh_next;
    logic [QSTEP_W-1:0] step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [CNT_W:0]     shifted;
    logic [CNT_W:0]     trial;
    logic               ge;

    // high part of the dividend is below the divisor, so 16 steps suffice
    assign shifted = {rem_reg, sh_reg[MEAN_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        sh_next   = sh_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = CNT_W'(sum >> FRAC_W);
            sh_next   = {sum[FRAC_W-1:0], {(MEAN_W-FRAC_W){1'b0}}};
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            sh_next   = {sh_reg[MEAN_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

`default_nettype wire

@@ sv/bao_core.sv @@
// ----------------------------------------------------------------------------
// Brightness average sequencer
// Run state, outlier check and the schedule of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bao_core
    import bao_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [DATA_W-1:0]    threshold,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [IN_DATA_W-1:0] in_data,
    input  wire logic                 in_last,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output bao_result_t               res
);

    localparam int SUM_W = DATA_W + $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    bao_state_t         state_reg, state_next;
    logic [DATA_W-1:0]  x_reg     [NUM_CH];
    logic [DATA_W-1:0]  x_next    [NUM_CH];
    logic [SUM_W-1:0]   sum_reg   [NUM_CH];
    logic [SUM_W-1:0]   sum_next  [NUM_CH];
    logic [MEAN_W-1:0]  rmean_reg [2];
    logic [MEAN_W-1:0]  rmean_next[2];
    logic [REJ_W-1:0]   rej_reg   [2];
    logic [REJ_W-1:0]   rej_next  [2];
    logic [1:0]         upd_reg,   upd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               last_reg,  last_next;
    logic               ch_reg,    ch_next;
    logic [2:0]         k_reg,     k_next;
    bao_result_t        res_reg,   res_next;

    logic [1:0]         reject;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   res_div;
    logic [2:0]         sum_idx;
    logic               div_start;
    logic [SUM_W-1:0]   div_sum;
    logic [CNT_W-1:0]   div_divisor;
    logic               div_done;
    logic [MEAN_W-1:0]  div_quot;

    bao_div #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sum     (div_sum),
        .divisor (div_divisor),
        .done    (div_done),
        .quot    (div_quot)
    );

    // |x*256 - mean| > threshold*256 on channels three and four
    always_comb
    begin
        logic [MEAN_W-1:0] xs;
        logic [MEAN_W-1:0] diff;
        for (int c = 0; c < 2; c++)
        begin
            xs        = {x_reg[2+c], {FRAC_W{1'b0}}};
            diff      = (xs > rmean_reg[c]) ? xs - rmean_reg[c] : rmean_reg[c] - xs;
            reject[c] = (count_reg != '0) && (rej_reg[c] == '0)
                        && (diff > {threshold, {FRAC_W{1'b0}}});
        end
    end

    assign n_eff = (count_reg == '0) ? ONE_CNT : count_reg;

    always_comb
    begin
        res_div = n_eff;
        if (k_reg == CH_THREE && rej_reg[0] != '0 && n_eff > ONE_CNT)
        begin
            res_div = n_eff - ONE_CNT;
        end
        else if (k_reg == CH_FOUR && rej_reg[1] != '0 && n_eff > ONE_CNT)
        begin
            res_div = n_eff - ONE_CNT;
        end
    end

    assign sum_idx = (state_reg == S_RES_START) ? k_reg : (ch_reg ? CH_FOUR : CH_THREE);
    assign div_sum = sum_reg[sum_idx];

    always_comb
    begin
        logic adv;
        adv         = 1'b0;
        state_next  = state_reg;
        x_next      = x_reg;
        sum_next    = sum_reg;
        rmean_next  = rmean_reg;
        rej_next    = rej_reg;
        upd_next    = upd_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        ch_next     = ch_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        div_start   = 1'b0;
        div_divisor = count_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        x_next[i] = in_data[i*DATA_W +: DATA_W];
                    end
                    last_next  = in_last;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (count_reg < MAX_CNT)
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        if (reject[c])
                        begin
                            rej_next[c] = REJ_W'(count_reg);
                        end
                        else
                        begin
                            sum_next[2+c] = sum_reg[2+c] + SUM_W'(x_reg[2+c]);
                        end
                        upd_next[c] = !reject[c] && (rej_reg[c] == '0);
                    end
                    sum_next[CH_ONE]  = sum_reg[CH_ONE]  + SUM_W'(x_reg[CH_ONE]);
                    sum_next[CH_TWO]  = sum_reg[CH_TWO]  + SUM_W'(x_reg[CH_TWO]);
                    sum_next[CH_MARK] = sum_reg[CH_MARK] + SUM_W'(x_reg[CH_MARK]);
                    count_next = count_reg + ONE_CNT;
                    ch_next    = 1'b0;
                    state_next = S_MEAN_START;
                end
                else
                begin
                    k_next     = CH_ONE;
                    state_next = last_reg ? S_RES_START : S_IDLE;
                end
            end
            S_MEAN_START:
            begin
                if (upd_reg[ch_reg])
                begin
                    div_start  = 1'b1;
                    state_next = S_MEAN_WAIT;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    rmean_next[ch_reg] = div_quot;
                    adv = 1'b1;
                end
            end
            S_RES_START:
            begin
                div_start   = 1'b1;
                div_divisor = res_div;
                state_next  = S_RES_WAIT;
            end
            S_RES_WAIT:
            begin
                if (div_done)
                begin
                    res_next.mean[k_reg] = div_quot;
                    if (k_reg == CH_MARK)
                    begin
                        res_next.rej_three = rej_reg[0];
                        res_next.rej_four  = rej_reg[1];
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = S_RES_START;
                    end
                end
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        sum_next[i] = '0;
                    end
                    rmean_next = '{default: '0};
                    rej_next   = '{default: '0};
                    upd_next   = '0;
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (!ch_reg)
            begin
                ch_next    = 1'b1;
                state_next = S_MEAN_START;
            end
            else if (last_reg)
            begin
                k_next     = CH_ONE;
                state_next = S_RES_START;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg   <= '{default: '0};
            rmean_reg <= '{default: '0};
            rej_reg   <= '{default: '0};
            upd_reg   <= '0;
            count_reg <= '0;
            last_reg  <= 1'b0;
            ch_reg    <= 1'b0;
            k_reg     <= CH_ONE;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            rmean_reg <= rmean_next;
            rej_reg   <= rej_next;
            upd_reg   <= upd_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            ch_reg    <= ch_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire
